// ===== sv/lres_pkg.sv =====
package lres_pkg;

    // Parse stack geometry.
    localparam int STACK_DEPTH = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH);

    typedef logic [SP_W-1:0] sp_t;
    typedef logic [4:0]      lr_state_t;

    // Lookahead classes, one bit each so that table entries can match a set.
    typedef logic [6:0] cls_t;
    localparam cls_t CLS_NONE  = 7'b000_0000;
    localparam cls_t CLS_EOS   = 7'b000_0001;
    localparam cls_t CLS_ADD   = 7'b000_0010;
    localparam cls_t CLS_MUL   = 7'b000_0100;
    localparam cls_t CLS_LP    = 7'b000_1000;
    localparam cls_t CLS_RP    = 7'b001_0000;
    localparam cls_t CLS_ALPHA = 7'b010_0000;
    localparam cls_t CLS_DIGIT = 7'b100_0000;
    localparam cls_t CLS_ENX   = CLS_EOS | CLS_ADD | CLS_RP;
    localparam cls_t CLS_TNX   = CLS_ENX | CLS_MUL;
    localparam cls_t CLS_ALNUM = CLS_ALPHA | CLS_DIGIT;

    // Verdict codes.
    localparam logic [1:0] VERDICT_PENDING  = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_REJECTED = 2'd2;

    typedef enum logic [2:0] {
        NT_E,
        NT_T,
        NT_F,
        NT_V,
        NT_N
    } nt_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_SHIFT,
        ACT_ACCEPT,
        ACT_REDUCE
    } act_kind_t;

    typedef struct packed {
        act_kind_t kind;
        lr_state_t target;
        logic [1:0] pop;
        nt_t        lhs;
    } action_t;

    // Stack port bundle between the core and the stack memory.
    typedef struct packed {
        logic      wr_en;
        sp_t       wr_addr;
        lr_state_t wr_data;
        sp_t       rd_addr;
    } stack_req_t;

    // Microcode: one control word per step.
    typedef enum logic [2:0] {
        UOP_FETCH,
        UOP_ACTION,
        UOP_GOTO,
        UOP_ENDCHK,
        UOP_EMIT
    } uop_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_FETCH  = 3'd0;
    localparam upc_t UPC_ACTION = 3'd1;
    localparam upc_t UPC_GOTO   = 3'd2;
    localparam upc_t UPC_ENDCHK = 3'd3;
    localparam upc_t UPC_EMIT   = 3'd4;

    typedef struct packed {
        uop_t op;
        upc_t nxt;
        upc_t jmp;
    } uword_t;

    // The sequencer program. Each word names its plain successor and the
    // target of its conditional jump.
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        case (pc)
            UPC_FETCH:  w = '{op: UOP_FETCH,  nxt: UPC_ACTION, jmp: UPC_ENDCHK};
            UPC_ACTION: w = '{op: UOP_ACTION, nxt: UPC_ENDCHK, jmp: UPC_GOTO};
            UPC_GOTO:   w = '{op: UOP_GOTO,   nxt: UPC_ACTION, jmp: UPC_ENDCHK};
            UPC_ENDCHK: w = '{op: UOP_ENDCHK, nxt: UPC_EMIT,   jmp: UPC_ACTION};
            UPC_EMIT:   w = '{op: UOP_EMIT,   nxt: UPC_FETCH,  jmp: UPC_EMIT};
            default:    w = '{op: UOP_FETCH,  nxt: UPC_FETCH,  jmp: UPC_FETCH};
        endcase
        return w;
    endfunction

    function automatic cls_t char_class(input logic [7:0] c);
        cls_t k;
        case (c) inside
            8'h24:          k = CLS_EOS;   // '$'
            8'h2B, 8'h2D:   k = CLS_ADD;   // '+' '-'
            8'h2A, 8'h2F:   k = CLS_MUL;   // '*' '/'
            8'h28:          k = CLS_LP;
            8'h29:          k = CLS_RP;
            [8'h61:8'h7A]:  k = CLS_ALPHA;
            [8'h30:8'h39]:  k = CLS_DIGIT;
            default:        k = CLS_NONE;
        endcase
        return k;
    endfunction

    function automatic action_t mk_shift(input lr_state_t s);
        action_t a;
        a = '{kind: ACT_SHIFT, target: s, pop: 2'd0, lhs: NT_E};
        return a;
    endfunction

    function automatic action_t mk_reduce(input logic [1:0] n, input nt_t nt);
        action_t a;
        a = '{kind: ACT_REDUCE, target: 5'd0, pop: n, lhs: nt};
        return a;
    endfunction

    // Action table: slots are tried in order, the first matching one wins.
    function automatic action_t action_lookup(input lr_state_t s, input cls_t c);
        action_t a;
        a = '{kind: ACT_NONE, target: 5'd0, pop: 2'd0, lhs: NT_E};
        case (s)
            5'd0, 5'd8, 5'd9, 5'd10: begin
                if ((c & CLS_ALPHA) != '0)      a = mk_shift(5'd6);
                else if ((c & CLS_DIGIT) != '0) a = mk_shift(5'd7);
                else if ((c & CLS_LP) != '0)    a = mk_shift(5'd8);
            end
            5'd1: begin
                if ((c & CLS_ADD) != '0)      a = mk_shift(5'd9);
                else if ((c & CLS_EOS) != '0) a.kind = ACT_ACCEPT;
            end
            5'd2: begin
                if ((c & CLS_MUL) != '0)      a = mk_shift(5'd10);
                else if ((c & CLS_ENX) != '0) a = mk_reduce(2'd1, NT_E);
            end
            5'd3: if ((c & CLS_TNX) != '0) a = mk_reduce(2'd1, NT_T);
            5'd4, 5'd5: if ((c & CLS_TNX) != '0) a = mk_reduce(2'd1, NT_F);
            5'd6: begin
                if ((c & CLS_ALNUM) != '0)    a = mk_shift(5'd6);
                else if ((c & CLS_TNX) != '0) a = mk_reduce(2'd1, NT_V);
            end
            5'd7: begin
                if ((c & CLS_DIGIT) != '0)    a = mk_shift(5'd7);
                else if ((c & CLS_TNX) != '0) a = mk_reduce(2'd1, NT_N);
            end
            5'd11: if ((c & CLS_TNX) != '0) a = mk_reduce(2'd2, NT_V);
            5'd12: if ((c & CLS_TNX) != '0) a = mk_reduce(2'd2, NT_N);
            5'd13: begin
                if ((c & CLS_RP) != '0)       a = mk_shift(5'd16);
                else if ((c & CLS_ADD) != '0) a = mk_shift(5'd9);
            end
            5'd14: begin
                if ((c & CLS_MUL) != '0)      a = mk_shift(5'd10);
                else if ((c & CLS_TNX) != '0) a = mk_reduce(2'd3, NT_T);
            end
            5'd15, 5'd16: if ((c & CLS_TNX) != '0) a = mk_reduce(2'd3, NT_F);
            default: ;
        endcase
        return a;
    endfunction

    // Goto table; zero means no entry.
    function automatic lr_state_t goto_lookup(input lr_state_t s, input nt_t nt);
        lr_state_t g;
        g = 5'd0;
        case (s)
            5'd0, 5'd8: begin
                case (nt)
                    NT_E:    g = (s == 5'd0) ? 5'd1 : 5'd13;
                    NT_T:    g = 5'd2;
                    NT_F:    g = 5'd3;
                    NT_V:    g = 5'd4;
                    NT_N:    g = 5'd5;
                    default: g = 5'd0;
                endcase
            end
            5'd6: if (nt == NT_V) g = 5'd11;
            5'd7: if (nt == NT_N) g = 5'd12;
            5'd9: begin
                case (nt)
                    NT_T:    g = 5'd14;
                    NT_F:    g = 5'd3;
                    NT_V:    g = 5'd4;
                    NT_N:    g = 5'd5;
                    default: g = 5'd0;
                endcase
            end
            5'd10: begin
                case (nt)
                    NT_F:    g = 5'd15;
                    NT_V:    g = 5'd4;
                    NT_N:    g = 5'd5;
                    default: g = 5'd0;
                endcase
            end
            default: ;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/lres_stack.sv =====
module lres_stack (
    input  logic                  clk,
    input  lres_pkg::stack_req_t  req,
    output lres_pkg::lr_state_t   rd_data
);

    lres_pkg::lr_state_t mem [lres_pkg::STACK_DEPTH];
    lres_pkg::lr_state_t rd_data_reg;
    logic                rd_bottom_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg   <= mem[req.rd_addr];
        rd_bottom_reg <= (req.rd_addr == '0);
    end

    // The bottom entry is never written; a read of it always returns the start state.
    assign rd_data = rd_bottom_reg ? 5'd0 : rd_data_reg;

endmodule

// ===== sv/lr_expression_syntax_checker_core.sv =====
// A character runs through the microcode steps fetch, action, end check and emit; each reduce
// adds a goto step, as the popped state comes from a registered stack read. Once the sentence
// holds a verdict, a character skips from fetch to the end check. A last character also runs
// the implicit end marker through the action steps. The next character is taken only at fetch,
// after the last one is emitted, even while that result waits in the output register.
// Reset (rst_n low, asynchronous) empties the stack, clears the verdict and overflow flag.
module lr_expression_syntax_checker_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [1:0] verdict,
    output logic       done_res,
    output logic       overflow,
    output logic       out_valid,
    input  logic       out_stall
);

    // Sequencer and parser control state.
    lres_pkg::upc_t      upc_reg,  upc_next;
    lres_pkg::sp_t       sp_reg,   sp_next;
    lres_pkg::lr_state_t top_reg,  top_next;
    logic [1:0]          held_reg, held_next;
    logic                ovf_reg,  ovf_next;
    logic                eos_reg,  eos_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers of the current character and of the result.
    lres_pkg::cls_t cls_reg,  cls_next;
    logic           last_reg, last_next;
    lres_pkg::nt_t  lhs_reg,  lhs_next;
    logic [1:0]     verdict_reg,  verdict_next;
    logic           done_reg,     done_next;
    logic           ovf_out_reg,  ovf_out_next;

    lres_pkg::uword_t     uw;
    lres_pkg::action_t    act;
    lres_pkg::lr_state_t  stk_rd;
    lres_pkg::lr_state_t  gto;
    lres_pkg::stack_req_t stk_req;
    lres_pkg::sp_t        pop_n;

    lres_stack u_stack (
        .clk     (clk),
        .req     (stk_req),
        .rd_data (stk_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= lres_pkg::UPC_FETCH;
            sp_reg        <= '0;
            top_reg       <= '0;
            held_reg      <= lres_pkg::VERDICT_PENDING;
            ovf_reg       <= 1'b0;
            eos_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            held_reg      <= held_next;
            ovf_reg       <= ovf_next;
            eos_reg       <= eos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg     <= cls_next;
        last_reg    <= last_next;
        lhs_reg     <= lhs_next;
        verdict_reg <= verdict_next;
        done_reg    <= done_next;
        ovf_out_reg <= ovf_out_next;
    end

    // The control word at the micro program counter picks the operation; the action
    // and goto tables are consulted with the cached top of stack and the popped state.
    always_comb
    begin
        uw    = lres_pkg::ucode(upc_reg);
        act   = lres_pkg::action_lookup(top_reg, cls_reg);
        gto   = lres_pkg::goto_lookup(stk_rd, lhs_reg);
        pop_n = lres_pkg::sp_t'(act.pop);

        upc_next       = upc_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        held_next      = held_reg;
        ovf_next       = ovf_reg;
        eos_next       = eos_reg;
        cls_next       = cls_reg;
        last_next      = last_reg;
        lhs_next       = lhs_reg;
        verdict_next   = verdict_reg;
        done_next      = done_reg;
        ovf_out_next   = ovf_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        stk_req.wr_en   = 1'b0;
        stk_req.wr_addr = sp_reg + 1'b1;
        stk_req.wr_data = act.target;
        stk_req.rd_addr = sp_reg;

        case (uw.op)
            lres_pkg::UOP_FETCH:
            begin
                if (in_valid)
                begin
                    cls_next  = lres_pkg::char_class(ch);
                    last_next = last;
                    eos_next  = 1'b0;
                    // A verdict already reached skips the parser for the rest of the sentence.
                    upc_next  = (held_reg != lres_pkg::VERDICT_PENDING) ? uw.jmp : uw.nxt;
                end
            end

            lres_pkg::UOP_ACTION:
            begin
                upc_next = uw.nxt;
                case (act.kind)
                    lres_pkg::ACT_NONE:
                    begin
                        held_next = lres_pkg::VERDICT_REJECTED;
                    end
                    lres_pkg::ACT_ACCEPT:
                    begin
                        held_next = lres_pkg::VERDICT_ACCEPTED;
                    end
                    lres_pkg::ACT_SHIFT:
                    begin
                        if (sp_reg == lres_pkg::sp_t'(lres_pkg::STACK_DEPTH - 1))
                        begin
                            ovf_next  = 1'b1;
                            held_next = lres_pkg::VERDICT_REJECTED;
                        end
                        else if (eos_reg)
                        begin
                            // Shifting the end marker can never finish the parse.
                            held_next = lres_pkg::VERDICT_REJECTED;
                        end
                        else
                        begin
                            stk_req.wr_en = 1'b1;
                            sp_next       = sp_reg + 1'b1;
                            top_next      = act.target;
                        end
                    end
                    lres_pkg::ACT_REDUCE:
                    begin
                        if (sp_reg < pop_n)
                        begin
                            held_next = lres_pkg::VERDICT_REJECTED;
                        end
                        else
                        begin
                            sp_next         = sp_reg - pop_n;
                            stk_req.rd_addr = sp_reg - pop_n;
                            lhs_next        = act.lhs;
                            upc_next        = uw.jmp;
                        end
                    end
                    default:
                    begin
                        held_next = lres_pkg::VERDICT_REJECTED;
                    end
                endcase
            end

            lres_pkg::UOP_GOTO:
            begin
                if (gto == '0)
                begin
                    held_next = lres_pkg::VERDICT_REJECTED;
                    upc_next  = uw.jmp;
                end
                else
                begin
                    stk_req.wr_en   = 1'b1;
                    stk_req.wr_data = gto;
                    sp_next         = sp_reg + 1'b1;
                    top_next        = gto;
                    upc_next        = uw.nxt;
                end
            end

            lres_pkg::UOP_ENDCHK:
            begin
                // After the last character, feed the implicit end marker once.
                if (last_reg && (held_reg == lres_pkg::VERDICT_PENDING) && !eos_reg)
                begin
                    cls_next = lres_pkg::CLS_EOS;
                    eos_next = 1'b1;
                    upc_next = uw.jmp;
                end
                else
                begin
                    upc_next = uw.nxt;
                end
            end

            lres_pkg::UOP_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = held_reg;
                    done_next      = last_reg;
                    ovf_out_next   = (held_reg == lres_pkg::VERDICT_REJECTED) && ovf_reg;
                    upc_next       = uw.nxt;
                    if (last_reg)
                    begin
                        // Sentence over: back to the start state for the next one.
                        sp_next   = '0;
                        top_next  = '0;
                        held_next = lres_pkg::VERDICT_PENDING;
                        ovf_next  = 1'b0;
                    end
                end
                else
                begin
                    upc_next = uw.jmp;
                end
            end

            default:
            begin
                upc_next = lres_pkg::UPC_FETCH;
            end
        endcase
    end

    assign in_stall  = (upc_reg != lres_pkg::UPC_FETCH);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign done_res  = done_reg;
    assign overflow  = ovf_out_reg;

endmodule

// ===== sv/lres_checker.sv =====
module lres_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] ch,
    input logic       last,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] verdict,
    input logic       done_res,
    input logic       overflow,
    input logic       out_valid,
    input logic       out_stall
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict)
            && $stable(done_res) && $stable(overflow))
        else $error("result changed while stalled");

    a_final_decided: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |->
            verdict == lres_pkg::VERDICT_ACCEPTED || verdict == lres_pkg::VERDICT_REJECTED)
        else $error("last result of a sentence has no verdict");

    a_ovf_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> verdict == lres_pkg::VERDICT_REJECTED)
        else $error("overflow flag without rejection");

    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict == lres_pkg::VERDICT_PENDING
            || verdict == lres_pkg::VERDICT_ACCEPTED || verdict == lres_pkg::VERDICT_REJECTED)
        else $error("verdict code out of range");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second character taken before the first was processed");

endmodule

bind lr_expression_syntax_checker_core lres_checker u_lres_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // A quiet stretch this long means the block has hung. The slowest legal gap
    // between two transfers is a long reduce chain behind a long output stall
    // and a long sender gap, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // Items to send in total before the run winds down.
    localparam int ITEM_TARGET    = 1100;
    // Cycles to keep watching after the last expected result has arrived.
    localparam int TAIL_CYCLES    = 96;
    localparam int N_LR_STATES    = 17;

    // Characters the stimulus builds sentences from.
    localparam logic [7:0] CH_END    = "$";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_A      = "a";
    localparam logic [7:0] CH_Z      = "z";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";

    // What the parser does with one lookahead in one state.
    typedef enum logic [1:0] {
        MV_NONE,
        MV_SHIFT,
        MV_ACCEPT,
        MV_REDUCE
    } move_kind_t;

    typedef struct packed {
        move_kind_t          kind;
        lres_pkg::lr_state_t dest;
        logic [1:0]          pops;
        lres_pkg::nt_t       lhs;
    } move_t;

    // How the handling of one lookahead ended.
    typedef enum logic [1:0] {
        FEED_SHIFTED,
        FEED_ACCEPT,
        FEED_REJECT
    } feed_t;

    // One expected result.
    typedef struct packed {
        logic [1:0] verdict;
        logic       done;
        logic       ovf;
    } verdict_rec_t;

    // Successor after a reduction, indexed by the uncovered state and the
    // nonterminal E, T, F, V, N. Zero marks a missing entry.
    localparam lres_pkg::lr_state_t GOTO_TAB [0:N_LR_STATES-1][0:4] = '{
        '{5'd1,  5'd2,  5'd3,  5'd4, 5'd5},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0, 5'd11, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd12},
        '{5'd13, 5'd2,  5'd3,  5'd4, 5'd5},
        '{5'd0,  5'd14, 5'd3,  5'd4, 5'd5},
        '{5'd0,  5'd0,  5'd15, 5'd4, 5'd5},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd0, 5'd0}
    };

    // The scoreboard keeps its own copy of the parser. Every accepted character
    // is run through it right away, and the verdict it yields is queued until
    // the block delivers the matching result transfer.
    class verdict_scoreboard;
        lres_pkg::lr_state_t stk [lres_pkg::STACK_DEPTH];
        int unsigned         top_idx;
        logic [1:0]          held;
        logic                ovf_flag;
        verdict_rec_t        verdict_q [$];

        int unsigned errors;
        int unsigned checked;
        int unsigned n_sentences;
        int unsigned n_accepted;
        int unsigned n_rejected;
        int unsigned n_overflow;

        function new();
            restart();
            errors      = 0;
            checked     = 0;
            n_sentences = 0;
            n_accepted  = 0;
            n_rejected  = 0;
            n_overflow  = 0;
        endfunction

        function void restart();
            foreach (stk[i]) stk[i] = 5'd0;
            top_idx  = 0;
            held     = lres_pkg::VERDICT_PENDING;
            ovf_flag = 1'b0;
        endfunction

        function int unsigned outstanding();
            return verdict_q.size();
        endfunction

        function lres_pkg::cls_t classify(input logic [7:0] c);
            if (c == CH_END) return lres_pkg::CLS_EOS;
            if (c == CH_PLUS || c == CH_MINUS) return lres_pkg::CLS_ADD;
            if (c == CH_STAR || c == CH_SLASH) return lres_pkg::CLS_MUL;
            if (c == CH_LPAREN) return lres_pkg::CLS_LP;
            if (c == CH_RPAREN) return lres_pkg::CLS_RP;
            if (c >= CH_A && c <= CH_Z) return lres_pkg::CLS_ALPHA;
            if (c >= CH_0 && c <= CH_9) return lres_pkg::CLS_DIGIT;
            return lres_pkg::CLS_NONE;
        endfunction

        function move_t shift_to(input lres_pkg::lr_state_t d);
            return '{kind: MV_SHIFT, dest: d, pops: 2'd0, lhs: lres_pkg::NT_E};
        endfunction

        function move_t reduce_by(input logic [1:0] n, input lres_pkg::nt_t nt);
            return '{kind: MV_REDUCE, dest: 5'd0, pops: n, lhs: nt};
        endfunction

        // Action table. The lookahead is a single class, so each test below
        // asks whether it belongs to the set that the slot accepts.
        function move_t move_for(input lres_pkg::lr_state_t s, input lres_pkg::cls_t k);
            move_t m;
            m = '{kind: MV_NONE, dest: 5'd0, pops: 2'd0, lhs: lres_pkg::NT_E};
            case (s)
                5'd0, 5'd8, 5'd9, 5'd10: begin
                    if ((k & lres_pkg::CLS_ALPHA) != '0)      m = shift_to(5'd6);
                    else if ((k & lres_pkg::CLS_DIGIT) != '0) m = shift_to(5'd7);
                    else if ((k & lres_pkg::CLS_LP) != '0)    m = shift_to(5'd8);
                end
                5'd1: begin
                    if ((k & lres_pkg::CLS_ADD) != '0)      m = shift_to(5'd9);
                    else if ((k & lres_pkg::CLS_EOS) != '0) m.kind = MV_ACCEPT;
                end
                5'd2: begin
                    if ((k & lres_pkg::CLS_MUL) != '0)      m = shift_to(5'd10);
                    else if ((k & lres_pkg::CLS_ENX) != '0) m = reduce_by(2'd1, lres_pkg::NT_E);
                end
                5'd3: if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd1, lres_pkg::NT_T);
                5'd4, 5'd5:
                    if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd1, lres_pkg::NT_F);
                5'd6: begin
                    if ((k & lres_pkg::CLS_ALNUM) != '0)    m = shift_to(5'd6);
                    else if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd1, lres_pkg::NT_V);
                end
                5'd7: begin
                    if ((k & lres_pkg::CLS_DIGIT) != '0)    m = shift_to(5'd7);
                    else if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd1, lres_pkg::NT_N);
                end
                5'd11: if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd2, lres_pkg::NT_V);
                5'd12: if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd2, lres_pkg::NT_N);
                5'd13: begin
                    if ((k & lres_pkg::CLS_RP) != '0)       m = shift_to(5'd16);
                    else if ((k & lres_pkg::CLS_ADD) != '0) m = shift_to(5'd9);
                end
                5'd14: begin
                    if ((k & lres_pkg::CLS_MUL) != '0)      m = shift_to(5'd10);
                    else if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd3, lres_pkg::NT_T);
                end
                5'd15, 5'd16:
                    if ((k & lres_pkg::CLS_TNX) != '0) m = reduce_by(2'd3, lres_pkg::NT_F);
                default: ;
            endcase
            return m;
        endfunction

        // Reduces until the lookahead is shifted, accepted or rejected.
        function feed_t consume(input lres_pkg::cls_t k);
            lres_pkg::lr_state_t cur;
            lres_pkg::lr_state_t nxt;
            move_t               m;
            while (1) begin
                cur = stk[top_idx];
                if (int'(cur) >= N_LR_STATES) return FEED_REJECT;
                m = move_for(cur, k);
                case (m.kind)
                    MV_NONE:   return FEED_REJECT;
                    MV_ACCEPT: return FEED_ACCEPT;
                    MV_SHIFT: begin
                        if (top_idx + 1 >= lres_pkg::STACK_DEPTH) begin
                            ovf_flag = 1'b1;
                            return FEED_REJECT;
                        end
                        top_idx++;
                        stk[top_idx] = m.dest;
                        return FEED_SHIFTED;
                    end
                    default: begin
                        if (top_idx < m.pops) return FEED_REJECT;
                        top_idx -= m.pops;
                        cur = stk[top_idx];
                        if (int'(cur) >= N_LR_STATES) return FEED_REJECT;
                        nxt = GOTO_TAB[cur][int'(m.lhs)];
                        if (nxt == 5'd0) return FEED_REJECT;
                        top_idx++;
                        stk[top_idx] = nxt;
                    end
                endcase
            end
        endfunction

        // Called for every character transfer into the block.
        function void note_char(input logic [7:0] c, input logic is_last);
            feed_t        r;
            verdict_rec_t e;
            if (held == lres_pkg::VERDICT_PENDING) begin
                r = consume(classify(c));
                if (r == FEED_ACCEPT) held = lres_pkg::VERDICT_ACCEPTED;
                else if (r == FEED_REJECT) held = lres_pkg::VERDICT_REJECTED;
            end
            // The end marker that follows the last character.
            if (is_last && held == lres_pkg::VERDICT_PENDING) begin
                r = consume(lres_pkg::CLS_EOS);
                held = (r == FEED_ACCEPT) ? lres_pkg::VERDICT_ACCEPTED
                                          : lres_pkg::VERDICT_REJECTED;
            end
            e.verdict = held;
            e.done    = is_last;
            e.ovf     = (held == lres_pkg::VERDICT_REJECTED) ? ovf_flag : 1'b0;
            verdict_q.insert(verdict_q.size(), e);
            if (is_last) begin
                n_sentences++;
                if (held == lres_pkg::VERDICT_ACCEPTED) n_accepted++;
                else n_rejected++;
                if (e.ovf) n_overflow++;
                restart();
            end
        endfunction

        // Called for every result transfer out of the block.
        function void check_result(input logic [1:0] v, input logic d, input logic o);
            verdict_rec_t e;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing expected: verdict=%0d done=%0b ovf=%0b",
                             $realtime, v, d, o);
                return;
            end
            e = verdict_q.pop_front();
            checked++;
            if (v !== e.verdict || d !== e.done || o !== e.ovf) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result %0d mismatch: expected verdict=%0d done=%0b ovf=%0b, %s",
                             $realtime, checked, e.verdict, e.done, e.ovf,
                             $sformatf("got verdict=%0d done=%0b ovf=%0b", v, d, o));
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic [7:0] ch;
    logic       last;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] verdict;
    logic       done_res;
    logic       overflow;
    logic       out_valid;
    logic       out_stall = 1'b0;

    verdict_scoreboard sb;

    // Idle rates in percent for the sender and the receiver. The main sequence
    // changes them from phase to phase, with zero giving full-rate stretches.
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int items_sent;

    lr_expression_syntax_checker_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .last      (last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .verdict   (verdict),
        .done_res  (done_res),
        .overflow  (overflow),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mostly short pauses with the occasional long one.
    function automatic int pick_idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // The receiver stalls in bursts. The stall is set at the falling edge so
    // that it is steady when the block samples it at the rising edge.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left <= pick_idle_len() - 1;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Every result transfer is checked at the edge where it happens.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(verdict, done_res, overflow);
    end

    // The watchdog restarts on any transfer in either direction.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sends one character. It is called at a falling edge and returns at the
    // falling edge after the transfer, leaving valid high so that back-to-back
    // characters need no change of valid at all.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
            gap = pick_idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last     <= is_last;
        do @(posedge clk); while (in_stall);
        sb.note_char(c, is_last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_sentence(input logic [7:0] s[$]);
        int i;
        for (i = 0; i < s.size(); i++)
            send_char(s[i], i == s.size() - 1);
    endtask

    // Appends one character to the end of a sentence under construction.
    function automatic void append_char(ref logic [7:0] s[$], input logic [7:0] c);
        s.insert(s.size(), c);
    endfunction

    task automatic send_text(input string txt);
        logic [7:0] s[$];
        int i;
        for (i = 0; i < txt.len(); i++)
            append_char(s, txt[i]);
        send_sentence(s);
    endtask

    // The sender holds back until the block has delivered everything owed.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return CH_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // A character that is likely to mean something to the parser, or any byte.
    function automatic logic [7:0] rand_symbol();
        case ($urandom_range(0, 9))
            0:       return CH_END;
            1:       return CH_PLUS;
            2:       return CH_MINUS;
            3:       return CH_STAR;
            4:       return CH_SLASH;
            5:       return CH_LPAREN;
            6:       return CH_RPAREN;
            7:       return rand_letter();
            8:       return rand_digit();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed expressions with random content: E is terms joined by +/-,
    // T is factors joined by * and /, and a factor is a name, a number, or a
    // bracketed expression while the nesting is still shallow.
    function automatic void add_factor(ref logic [7:0] s[$], input int lvl);
        int r;
        int n;
        r = $urandom_range(0, 9);
        if (lvl < 3 && r < 3) begin
            append_char(s, CH_LPAREN);
            add_expr(s, lvl + 1);
            append_char(s, CH_RPAREN);
        end else if (r < 6) begin
            append_char(s, rand_letter());
            n = $urandom_range(0, 3);
            repeat (n) append_char(s, $urandom_range(0, 1) ? rand_letter() : rand_digit());
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) append_char(s, rand_digit());
        end
    endfunction

    function automatic void add_term(ref logic [7:0] s[$], input int lvl);
        int n;
        int i;
        n = $urandom_range(1, 2);
        for (i = 0; i < n; i++) begin
            if (i > 0) append_char(s, $urandom_range(0, 1) ? CH_STAR : CH_SLASH);
            add_factor(s, lvl);
        end
    endfunction

    function automatic void add_expr(ref logic [7:0] s[$], input int lvl);
        int n;
        int i;
        n = (lvl == 0) ? $urandom_range(1, 3) : $urandom_range(1, 2);
        for (i = 0; i < n; i++) begin
            if (i > 0) append_char(s, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            add_term(s, lvl);
        end
    endfunction

    // Sentences that push the stack to and past its depth: deep brackets, a
    // long name or a long number.
    function automatic void add_deep(ref logic [7:0] s[$]);
        int d;
        d = $urandom_range(24, 36);
        case ($urandom_range(0, 2))
            0: begin
                repeat (d) append_char(s, CH_LPAREN);
                append_char(s, rand_letter());
                repeat (d) append_char(s, CH_RPAREN);
            end
            1: begin
                append_char(s, rand_letter());
                repeat (d - 1) append_char(s, $urandom_range(0, 1) ? rand_letter() : rand_digit());
            end
            default: repeat (d) append_char(s, rand_digit());
        endcase
    endfunction

    // Breaks a well-formed sentence in one place.
    function automatic void damage(ref logic [7:0] s[$]);
        int p;
        p = $urandom_range(0, s.size() - 1);
        case ($urandom_range(0, 3))
            0: s[p] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : rand_symbol();
            1: s = s[0:p];
            2: s.insert(p, CH_END);
            default: s.insert(p, rand_symbol());
        endcase
    endfunction

    initial begin
        logic [7:0] s[$];
        int         kind;
        int         n_sent_random;
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        ch             = 8'h00;
        last           = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        items_sent     = 0;
        n_sent_random  = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed sentences: a lone name; an early end marker that accepts in
        // the middle, after which the held verdict covers the remaining
        // character; the lowest and highest byte values, which belong to no
        // class; every operator and bracket in one valid sentence; an early
        // rejection that holds; an unclosed bracket rejected by the end marker;
        // a stray close bracket; a bare end marker.
        send_text("a");
        send_text("a$b");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("(7-z)/x*0+q2");
        send_text("+)");
        send_text("(");
        send_text("a)");
        send_text("$");

        // Let everything drain once before the random part starts.
        hold_until_drained();

        while (items_sent < ITEM_TARGET) begin
            // New idle rates every dozen sentences, sometimes none at all.
            if (n_sent_random % 12 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                    1: begin send_idle_pct = 25; recv_idle_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_idle_pct = 30; end
                    default: begin send_idle_pct = 40; recv_idle_pct = 40; end
                endcase
            end

            s.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                add_expr(s, 0);
            end else if (kind < 85) begin
                add_expr(s, 0);
                damage(s);
            end else if (kind < 93) begin
                repeat ($urandom_range(1, 6)) append_char(s, 8'($urandom_range(0, 255)));
            end else begin
                add_deep(s);
            end
            send_sentence(s);
            n_sent_random++;

            if ($urandom_range(0, 24) == 0) hold_until_drained();
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d sentences, %0d characters: %0d accepted, %0d rejected (%0d by overflow).",
                 sb.n_sentences, items_sent, sb.n_accepted, sb.n_rejected, sb.n_overflow);
        $display("Checked %0d results, %0d errors.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lres_pkg.sv
sv/lres_stack.sv
sv/lr_expression_syntax_checker_core.sv
sv/lres_checker.sv
tb/sv/tb_top.sv
